// File: design/ipv4dq_pkg.sv
// ipv4dq_pkg: shared types and character constants for the dotted-quad parser
// no dependencies; imported by every parser module

package ipv4dq_pkg;

   // character codes
   localparam logic [7:0] DOT_BYTE   = 8'h2E;
   localparam logic [7:0] PLUS_BYTE  = 8'h2B;
   localparam logic [7:0] MINUS_BYTE = 8'h2D;
   localparam logic [7:0] ZERO_BYTE  = 8'h30;
   localparam logic [7:0] NINE_BYTE  = 8'h39;
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] TAB_BYTE   = 8'h09;
   localparam logic [7:0] CR_BYTE    = 8'h0D;

   // text rules
   localparam logic [2:0] MIN_LENGTH = 3'd7;
   localparam logic [2:0] SEGMENTS   = 3'd4;
   localparam int         OCTETS     = 4;

   // number scan phase within one segment
   typedef enum logic [1:0] {
      PH_LEAD   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // one input beat
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } beat_type;

   // one result beat
   typedef struct packed {
      logic        address_valid;
      logic [31:0] address_value;
   } result_type;

endpackage

// File: design/ipv4dq_if.sv
// ipv4dq_req_if / ipv4dq_rsp_if: valid/ready channels for text bytes and results
// no dependencies beyond the width conventions of ipv4dq_pkg

interface ipv4dq_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ipv4dq_rsp_if;
   logic        valid;
   logic        ready;
   logic        address_valid;
   logic [31:0] address_value;

   modport source (output valid, output address_valid, output address_value, input ready);
   modport sink   (input valid, input address_valid, input address_value, output ready);
endinterface

// File: design/ipv4dq_in_stage.sv
// ipv4dq_in_stage: input register for text bytes, with the advance decision
// depends on ipv4dq_pkg and ipv4dq_req_if

module ipv4dq_in_stage
   import ipv4dq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ipv4dq_req_if.sink   req_bus,
   input  logic         out_free,
   output beat_type     beat,
   output logic         advance
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;

   // a non-final byte always advances; the final byte needs a free result slot
   assign advance      = valid_ff && (!beat_ff.end_of_text || out_free);
   assign req_bus.ready = !valid_ff || advance;
   assign beat         = beat_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_bus.ready) begin
         valid_in = req_bus.valid;
      end
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         beat_ff.text_byte   <= req_bus.text_byte;
         beat_ff.end_of_text <= req_bus.end_of_text;
      end
   end

endmodule

// File: design/ipv4dq_parse_core.sv
// ipv4dq_parse_core: per-byte segment scanner, octet store and final verdict
// depends on ipv4dq_pkg

module ipv4dq_parse_core
   import ipv4dq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  beat_type   beat,
   input  logic       advance,
   output result_type result
);

   logic [2:0] count_ff,  count_in;
   logic       failed_ff, failed_in;
   logic [7:0] value_ff,  value_in;
   logic       neg_ff,    neg_in;
   phase_type  phase_ff,  phase_in;
   logic       hb_ff,     hb_in;
   logic       ht_ff,     ht_in;
   logic [2:0] len_ff,    len_in;
   logic [7:0] octet_ff [OCTETS];
   logic [7:0] octet_in [OCTETS];

   logic       is_dot;
   logic       is_space;
   logic       is_digit;
   logic [7:0] digit;
   logic [7:0] f_value;
   logic       f_neg;
   phase_type  f_phase;
   logic       f_ht;
   logic       c_hb;
   logic       c_ht;
   logic       c_neg;
   logic [7:0] c_value;
   logic [7:0] c_octet;
   logic       close_seg;
   logic       seg_bad;

   // byte classes
   always_comb begin
      is_dot   = (beat.text_byte == DOT_BYTE);
      is_space = ((beat.text_byte >= TAB_BYTE) && (beat.text_byte <= CR_BYTE)) ||
                 (beat.text_byte == SPACE_BYTE);
      is_digit = (beat.text_byte >= ZERO_BYTE) && (beat.text_byte <= NINE_BYTE);
      digit    = beat.text_byte - ZERO_BYTE;
   end

   // atoi-style scan of one byte into the current segment
   always_comb begin
      f_value = value_ff;
      f_neg   = neg_ff;
      f_phase = phase_ff;
      f_ht    = ht_ff | !is_space;
      case (phase_ff)
         PH_LEAD: begin
            if (is_space) begin
               f_phase = PH_LEAD;
            end else if (beat.text_byte == PLUS_BYTE) begin
               f_phase = PH_SIGN;
            end else if (beat.text_byte == MINUS_BYTE) begin
               f_neg   = 1'b1;
               f_phase = PH_SIGN;
            end else if (is_digit) begin
               f_value = digit;
               f_phase = PH_DIGITS;
            end else begin
               f_phase = PH_DONE;
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
               f_value = (value_ff << 3) + (value_ff << 1) + digit;
               f_phase = PH_DIGITS;
            end else begin
               f_phase = PH_DONE;
            end
         end
         default: begin
            f_phase = PH_DONE;
         end
      endcase
   end

   // segment close on a dot, or on the final byte after feeding it
   always_comb begin
      close_seg = !failed_ff && (is_dot || beat.end_of_text);
      c_hb      = is_dot ? hb_ff    : 1'b1;
      c_ht      = is_dot ? ht_ff    : f_ht;
      c_neg     = is_dot ? neg_ff   : f_neg;
      c_value   = is_dot ? value_ff : f_value;
      c_octet   = c_neg ? (8'd0 - c_value) : c_value;
      seg_bad   = !c_hb || !c_ht || (count_ff >= SEGMENTS);
   end

   // next state and verdict
   always_comb begin
      len_in    = (len_ff == MIN_LENGTH) ? len_ff : len_ff + 3'd1;
      failed_in = failed_ff | (close_seg & seg_bad);
      count_in  = count_ff;
      octet_in  = octet_ff;
      if (close_seg && !seg_bad) begin
         count_in                 = count_ff + 3'd1;
         octet_in[count_ff[1:0]]  = c_octet;
      end

      value_in = value_ff;
      neg_in   = neg_ff;
      phase_in = phase_ff;
      hb_in    = hb_ff;
      ht_in    = ht_ff;
      if (close_seg) begin
         value_in = 8'd0;
         neg_in   = 1'b0;
         phase_in = PH_LEAD;
         hb_in    = 1'b0;
         ht_in    = 1'b0;
      end else if (!failed_ff) begin
         value_in = f_value;
         neg_in   = f_neg;
         phase_in = f_phase;
         hb_in    = 1'b1;
         ht_in    = f_ht;
      end

      result.address_valid = !failed_in && (count_in == SEGMENTS) && (len_in == MIN_LENGTH);
      result.address_value = result.address_valid ?
                             {octet_in[0], octet_in[1], octet_in[2], octet_in[3]} : 32'd0;

      // final byte returns the scanner to its start state
      if (beat.end_of_text) begin
         count_in  = 3'd0;
         failed_in = 1'b0;
         len_in    = 3'd0;
         value_in  = 8'd0;
         neg_in    = 1'b0;
         phase_in  = PH_LEAD;
         hb_in     = 1'b0;
         ht_in     = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 3'd0;
         failed_ff <= 1'b0;
         value_ff  <= 8'd0;
         neg_ff    <= 1'b0;
         phase_ff  <= PH_LEAD;
         hb_ff     <= 1'b0;
         ht_ff     <= 1'b0;
         len_ff    <= 3'd0;
      end else if (advance) begin
         count_ff  <= count_in;
         failed_ff <= failed_in;
         value_ff  <= value_in;
         neg_ff    <= neg_in;
         phase_ff  <= phase_in;
         hb_ff     <= hb_in;
         ht_ff     <= ht_in;
         len_ff    <= len_in;
      end
   end

   // octet store, only read once all four are written for the current text
   always_ff @(posedge clock) begin
      if (advance) begin
         octet_ff <= octet_in;
      end
   end

endmodule

// File: design/ipv4dq_out_stage.sv
// ipv4dq_out_stage: result register driving the response channel
// depends on ipv4dq_pkg and ipv4dq_rsp_if

module ipv4dq_out_stage
   import ipv4dq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  result_type   result,
   ipv4dq_rsp_if.source rsp_bus,
   output logic         out_free
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free              = !valid_ff || rsp_bus.ready;
   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.address_valid = result_ff.address_valid;
   assign rsp_bus.address_value = result_ff.address_value;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = load;
      end
   end

   // result occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

// File: design/ipv4_dotted_quad_parser.sv
// ipv4_dotted_quad_parser: dotted-quad text to 32-bit address, one byte per beat
// the final byte passes the input register, then the result register, before its result beat is offered
// throughput: one text byte per cycle, set by the segment scanner, which takes a byte on every advance
// non-final bytes keep flowing while a result waits; a final byte waits for the result slot
// reset (synchronous, active high) empties both registers and restarts the scan
// depends on ipv4dq_pkg, ipv4dq_if and the ipv4dq stage modules

module ipv4_dotted_quad_parser
   import ipv4dq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ipv4dq_req_if.sink   req_bus,
   ipv4dq_rsp_if.source rsp_bus
);

   beat_type   beat;
   result_type result;
   logic       advance;
   logic       out_free;

   // input register
   ipv4dq_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .out_free (out_free),
      .beat     (beat),
      .advance  (advance)
   );

   // segment scanner and verdict
   ipv4dq_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .advance (advance),
      .result  (result)
   );

   // result register, loaded by the final byte
   ipv4dq_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && beat.end_of_text),
      .result   (result),
      .rsp_bus  (rsp_bus),
      .out_free (out_free)
   );

endmodule

// File: design/ipv4dq_checker.sv
// ipv4dq_checker: port-level assertions for the dotted-quad parser
// depends on ipv4_dotted_quad_parser; attached by the bind below

module ipv4dq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        address_valid,
   input logic [31:0] address_value
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(address_valid) &&
                                  $stable(address_value))
      else $error("result beat changed while stalled");

   // rejected texts report a zero address
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !address_valid |-> address_value == 32'd0)
      else $error("rejected text with nonzero address");

   // input only stalls behind a result the sink is not taking
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .address_valid (rsp_bus.address_valid),
   .address_value (rsp_bus.address_value)
);
